@@ rtl/switch_run_length_deglitcher_assert.svh @@
// assertion macros shared by the deglitcher modules
// depends on a signal named clock and a signal named reset in the including module
`ifndef SWITCH_RUN_LENGTH_DEGLITCHER_ASSERT_SVH
`define SWITCH_RUN_LENGTH_DEGLITCHER_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define SRLD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while reset is high
`define SRLD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/srld_pkg.sv @@
// types, constants and helpers for the switch run-length deglitcher
// no dependencies
`timescale 1ns / 1ps

package srld_pkg;

   localparam int COUNT_BITS     = 20;
   localparam int TIME_BITS      = 32;
   localparam int KEEP_BITS      = 16;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = COUNT_BITS;
   localparam int MAX_BURST      = 3;
   localparam int BURST_CNT_BITS = 2;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [KEEP_BITS-1:0]  keep_type;

   localparam count_type COUNT_MAX   = {COUNT_BITS{1'b1}};
   localparam count_type COUNT_ONE   = count_type'(1);
   localparam count_type LIFT_RESET  = count_type'(1500);

   // register indexes of the configuration port
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_KEEP_LEN   = 2'd0,
      CSR_LIFT_LIMIT = 2'd1
   } csr_addr_type;

   typedef struct packed {
      time_type sample_time;
      logic     switch_level;
      logic     end_of_data;
   } req_type;

   typedef struct packed {
      time_type  run_start_time;
      count_type run_length;
      logic      run_level;
      logic      last_of_burst;
   } rsp_type;

   // one run handed from front to back; merged high runs get their level in the back
   typedef struct packed {
      time_type  start;
      count_type length;
      logic      is_merge;
      logic      level;
   } run_rec_type;

   // all runs caused by one request
   typedef struct packed {
      run_rec_type [MAX_BURST-1:0] recs;
      logic [BURST_CNT_BITS-1:0]   num;
   } burst_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // saturating count add
   function automatic count_type sat_add(count_type a, count_type b);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum[COUNT_BITS]) begin
         return COUNT_MAX;
      end
      return sum[COUNT_BITS-1:0];
   endfunction

endpackage

@@ rtl/switch_run_length_deglitcher.sv @@
// Run-length deglitcher for one foot-switch channel.
// Takes timestamped switch samples on the req_ channel and returns whole runs
// (start time, sample count, corrected level) on the rsp_ channel.
// Configuration: csr_ channel, index 0 keep_len, index 1 long_lift_limit;
// csr_ready is always high; write only while the block is idle.
// A request is taken when req_valid is high and req_stall low; a result
// leaves when rsp_valid is high and rsp_stall low.
// Throughput: one request per cycle as long as the four-entry burst queue
// has room; results leave one per cycle while rsp_stall is low, and a request
// that causes two or three runs holds the result side until all have left.
// A request's first run reaches rsp_ via the burst queue and result register.
// last_of_burst marks the final run caused by one request; requests that
// only lengthen the open run cause nothing.
// Receiver stall: results hold in the output register, the queue fills, and
// req_stall rises once all four queue entries are in use.
// Reset (synchronous): clears run state, queue and output, and sets
// keep_len to 0 and long_lift_limit to 1500.
// depends on srld_pkg, srld_front, srld_queue, srld_back
`timescale 1ns / 1ps

module switch_run_length_deglitcher (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  srld_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output srld_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [srld_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [srld_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import srld_pkg::*;

   keep_type         keep_len_ff, keep_len_in;
   count_type        lift_limit_ff, lift_limit_in;
   logic             q_wr_en;
   logic             q_rd_en;
   burst_type        q_wr_data;
   burst_type        q_rd_data;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      keep_len_in   = keep_len_ff;
      lift_limit_in = lift_limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEEP_LEN:   keep_len_in   = csr_wdata[KEEP_BITS-1:0];
            CSR_LIFT_LIMIT: lift_limit_in = csr_wdata[COUNT_BITS-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_len_ff   <= '0;
         lift_limit_ff <= LIFT_RESET;
      end else begin
         keep_len_ff   <= keep_len_in;
         lift_limit_ff <= lift_limit_in;
      end
   end

   srld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .keep_len  (keep_len_ff),
      .q_status  (q_status),
      .q_wr_en   (q_wr_en),
      .q_wr_data (q_wr_data)
   );

   srld_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_data (q_wr_data),
      .rd_en   (q_rd_en),
      .rd_data (q_rd_data),
      .status  (q_status)
   );

   srld_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_rd_data       (q_rd_data),
      .q_status        (q_status),
      .q_rd_en         (q_rd_en),
      .long_lift_limit (lift_limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule

@@ rtl/srld_front.sv @@
// front end: takes requests, tracks the open run and the high merge, builds result bursts
// depends on srld_pkg and switch_run_length_deglitcher_assert.svh
`timescale 1ns / 1ps

module srld_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  srld_pkg::req_type   req_data,
   output logic                req_stall,
   input  srld_pkg::keep_type  keep_len,
   input  srld_pkg::queue_status_type q_status,
   output logic                q_wr_en,
   output srld_pkg::burst_type q_wr_data
);
   import srld_pkg::*;

   logic      open_valid_ff, open_valid_in;
   logic      open_level_ff, open_level_in;
   time_type  open_start_ff, open_start_in;
   count_type open_count_ff, open_count_in;
   logic      trusted_ff, trusted_in;
   logic      merge_valid_ff, merge_valid_in;
   time_type  merge_start_ff, merge_start_in;
   count_type merge_count_ff, merge_count_in;

   logic                      accept;
   logic                      close_lvl;
   count_type                 keep_ext;
   logic [BURST_CNT_BITS-1:0] num;
   burst_type                 burst;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign keep_ext  = count_type'(keep_len);

   // run tracking and burst assembly
   always_comb begin
      open_valid_in  = open_valid_ff;
      open_level_in  = open_level_ff;
      open_start_in  = open_start_ff;
      open_count_in  = open_count_ff;
      trusted_in     = trusted_ff;
      merge_valid_in = merge_valid_ff;
      merge_start_in = merge_start_ff;
      merge_count_in = merge_count_ff;
      burst          = '0;
      num            = '0;
      close_lvl      = 1'b0;

      if (accept) begin
         if (open_valid_ff && (req_data.switch_level == open_level_ff)) begin
            open_count_in = sat_add(open_count_ff, COUNT_ONE);
         end else begin
            // level change closes the open run
            if (open_valid_ff) begin
               close_lvl  = (open_count_ff <= keep_ext) ? trusted_ff : open_level_ff;
               trusted_in = close_lvl;
               if (close_lvl) begin
                  if (merge_valid_in) begin
                     merge_count_in = sat_add(merge_count_in, open_count_ff);
                  end else begin
                     merge_valid_in = 1'b1;
                     merge_start_in = open_start_ff;
                     merge_count_in = open_count_ff;
                  end
               end else begin
                  if (merge_valid_in) begin
                     burst.recs[num] = '{start: merge_start_in, length: merge_count_in,
                                         is_merge: 1'b1, level: 1'b1};
                     num = num + 2'd1;
                  end
                  merge_valid_in  = 1'b0;
                  merge_start_in  = '0;
                  merge_count_in  = '0;
                  burst.recs[num] = '{start: open_start_ff, length: open_count_ff,
                                      is_merge: 1'b0, level: 1'b0};
                  num = num + 2'd1;
               end
            end
            open_valid_in = 1'b1;
            open_level_in = req_data.switch_level;
            open_start_in = req_data.sample_time;
            open_count_in = COUNT_ONE;
         end

         // flush: close the open run, emit the merge, clear everything
         if (req_data.end_of_data) begin
            close_lvl = (open_count_in <= keep_ext) ? trusted_in : open_level_in;
            if (close_lvl) begin
               if (merge_valid_in) begin
                  merge_count_in = sat_add(merge_count_in, open_count_in);
               end else begin
                  merge_valid_in = 1'b1;
                  merge_start_in = open_start_in;
                  merge_count_in = open_count_in;
               end
            end else begin
               if (merge_valid_in) begin
                  burst.recs[num] = '{start: merge_start_in, length: merge_count_in,
                                      is_merge: 1'b1, level: 1'b1};
                  num = num + 2'd1;
               end
               merge_valid_in  = 1'b0;
               burst.recs[num] = '{start: open_start_in, length: open_count_in,
                                   is_merge: 1'b0, level: 1'b0};
               num = num + 2'd1;
            end
            if (merge_valid_in) begin
               burst.recs[num] = '{start: merge_start_in, length: merge_count_in,
                                   is_merge: 1'b1, level: 1'b1};
               num = num + 2'd1;
            end
            open_valid_in  = 1'b0;
            open_level_in  = 1'b0;
            open_start_in  = '0;
            open_count_in  = '0;
            trusted_in     = 1'b0;
            merge_valid_in = 1'b0;
            merge_start_in = '0;
            merge_count_in = '0;
         end
      end
      burst.num = num;
   end

   assign q_wr_en   = accept && (num != '0);
   assign q_wr_data = burst;

   // run state
   always_ff @(posedge clock) begin
      if (reset) begin
         open_valid_ff  <= 1'b0;
         open_level_ff  <= 1'b0;
         open_start_ff  <= '0;
         open_count_ff  <= '0;
         trusted_ff     <= 1'b0;
         merge_valid_ff <= 1'b0;
         merge_start_ff <= '0;
         merge_count_ff <= '0;
      end else begin
         open_valid_ff  <= open_valid_in;
         open_level_ff  <= open_level_in;
         open_start_ff  <= open_start_in;
         open_count_ff  <= open_count_in;
         trusted_ff     <= trusted_in;
         merge_valid_ff <= merge_valid_in;
         merge_start_ff <= merge_start_in;
         merge_count_ff <= merge_count_in;
      end
   end

`include "switch_run_length_deglitcher_assert.svh"

   `SRLD_ASSERT_NOW(a_front_burst_size, q_wr_en, (q_wr_data.num != '0) && (q_wr_data.num <= 2'd3), "front pushed a burst of bad size")
   `SRLD_ASSERT_NEXT(a_front_flush_clears, accept && req_data.end_of_data, !open_valid_ff && !merge_valid_ff, "flush left run state behind")

endmodule

@@ rtl/srld_queue.sv @@
// short queue of result bursts between front and back
// depends on srld_pkg and switch_run_length_deglitcher_assert.svh
`timescale 1ns / 1ps

module srld_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  srld_pkg::burst_type          wr_data,
   input  logic                         rd_en,
   output srld_pkg::burst_type          rd_data,
   output srld_pkg::queue_status_type   status
);
   import srld_pkg::*;

   burst_type                 slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign rd_data      = slots_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

`include "switch_run_length_deglitcher_assert.svh"

   `SRLD_ASSERT_NOW(a_queue_no_overflow, wr_en, !status.full, "write into full queue")
   `SRLD_ASSERT_NOW(a_queue_no_underflow, rd_en, !status.empty, "read from empty queue")
   `SRLD_ASSERT_NEXT(a_queue_count_up, wr_en && !rd_en, count_ff == $past(count_ff) + 1'b1, "queue fill count lost a write")

endmodule

@@ rtl/srld_back.sv @@
// back end: moves bursts one run per unstalled cycle to the result register
// depends on srld_pkg and switch_run_length_deglitcher_assert.svh
`timescale 1ns / 1ps

module srld_back (
   input  logic                       clock,
   input  logic                       reset,
   input  srld_pkg::burst_type        q_rd_data,
   input  srld_pkg::queue_status_type q_status,
   output logic                       q_rd_en,
   input  srld_pkg::count_type        long_lift_limit,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output srld_pkg::rsp_type          rsp_data
);
   import srld_pkg::*;

   logic [BURST_CNT_BITS-1:0] idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   run_rec_type rec;
   logic        out_free;
   logic        last;

   assign rec      = q_rd_data.recs[idx_ff];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last     = (idx_ff == q_rd_data.num - 2'd1);

   // load the next run when the result register frees up
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      q_rd_en      = 1'b0;
      if (out_free) begin
         rsp_valid_in = !q_status.empty;
         if (!q_status.empty) begin
            rsp_data_in.run_start_time = rec.start;
            rsp_data_in.run_length     = rec.length;
            // long merged lift counts as ground contact
            rsp_data_in.run_level      = rec.is_merge ? (rec.length < long_lift_limit)
                                                      : rec.level;
            rsp_data_in.last_of_burst  = last;
            if (last) begin
               idx_in  = '0;
               q_rd_en = 1'b1;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "switch_run_length_deglitcher_assert.svh"

   `SRLD_ASSERT_NOW(a_back_idx_in_burst, !q_status.empty, idx_ff < q_rd_data.num, "run index beyond burst")

endmodule

@@ tb/sv/tb_switch_run_length_deglitcher.sv @@
// self-checking testbench for the switch run-length deglitcher
// drives directed and random sample requests, predicts the emitted runs in place
// depends on srld_pkg and switch_run_length_deglitcher
`timescale 1ns / 1ps

module tb_switch_run_length_deglitcher;
   import srld_pkg::*;

   localparam int LIMIT_CYCLES     = 200_000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int DRAIN_GUARD      = 100_000;
   localparam int HOLD_CYCLES      = 80;
   localparam int RANDOM_PER_PHASE = 52;
   localparam int PRESSURE_SAMPLES = 24;
   localparam int REPORT_LIMIT     = 10;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_INDEX = 2'd3;

   // one line of the directed stimulus: a register write or a sample request
   typedef struct packed {
      logic                     is_csr;
      logic [CSR_ADDR_BITS-1:0] csr_idx;
      count_type                csr_val;
      req_type                  req;
      logic                     typed;
      logic [1:0]               ntyped;
      rsp_type [MAX_BURST-1:0]  typed_runs;
   } step_row_type;

   logic                     clock;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_ADDR_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // predicted block state and configuration
   keep_type  keep_cfg    = '0;
   count_type lift_cfg    = LIFT_RESET;
   logic      open_valid  = 1'b0;
   logic      open_level  = 1'b0;
   time_type  open_start  = '0;
   count_type open_count  = '0;
   logic      trusted     = 1'b0;
   logic      merge_valid = 1'b0;
   time_type  merge_start = '0;
   count_type merge_count = '0;

   rsp_type      burst_runs[$];
   rsp_type      pending_runs[$];
   step_row_type steps[$];

   // pacing and bookkeeping
   int   idle_pct      = 0;
   int   stall_pct     = 0;
   logic hold_request  = 1'b0;
   int   cycle_count   = 0;
   int   samples_sent  = 0;
   int   runs_seen     = 0;
   int   csr_writes    = 0;
   int   mismatches    = 0;
   int   pressure_holds = 0;

   // random stream state
   time_type stamp    = '0;
   logic     walk_lvl = 1'b0;
   int       run_left = 0;

   switch_run_length_deglitcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // saturating count add
   function automatic count_type count_add(count_type a, count_type b);
      logic [COUNT_BITS:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[COUNT_BITS] ? COUNT_MAX : total[COUNT_BITS-1:0];
   endfunction

   function automatic rsp_type make_run(time_type start, count_type len, logic lvl,
                                        logic last);
      rsp_type r;
      r.run_start_time = start;
      r.run_length     = len;
      r.run_level      = lvl;
      r.last_of_burst  = last;
      return r;
   endfunction

   function automatic req_type make_sample(time_type t, logic lvl, logic eod);
      req_type r;
      r.sample_time  = t;
      r.switch_level = lvl;
      r.end_of_data  = eod;
      return r;
   endfunction

   task automatic queue_run(time_type start, count_type len, logic lvl);
      if (burst_runs.size() < MAX_BURST) begin
         burst_runs.insert(burst_runs.size(), make_run(start, len, lvl, 1'b0));
      end
   endtask

   // emit the pending merged high run, low when it reached the lift limit
   task automatic release_merge();
      if (merge_valid) begin
         queue_run(merge_start, merge_count, (merge_count >= lift_cfg) ? 1'b0 : 1'b1);
      end
      merge_valid = 1'b0;
      merge_start = '0;
      merge_count = '0;
   endtask

   // second stage: merge high runs, pass low runs
   task automatic merge_stage(time_type start, count_type len, logic lvl);
      if (lvl) begin
         if (merge_valid) begin
            merge_count = count_add(merge_count, len);
         end else begin
            merge_valid = 1'b1;
            merge_start = start;
            merge_count = len;
         end
      end else begin
         release_merge();
         queue_run(start, len, 1'b0);
      end
   endtask

   // short runs take the trusted level
   function automatic logic closing_level();
      return (open_count <= count_type'(keep_cfg)) ? trusted : open_level;
   endfunction

   task automatic clear_runs();
      open_valid  = 1'b0;
      open_level  = 1'b0;
      open_start  = '0;
      open_count  = '0;
      trusted     = 1'b0;
      merge_valid = 1'b0;
      merge_start = '0;
      merge_count = '0;
   endtask

   // runs caused by one sample request, left in burst_runs
   task automatic predict_runs(req_type r);
      logic lvl;
      burst_runs.delete();
      if (open_valid && r.switch_level == open_level) begin
         open_count = count_add(open_count, COUNT_ONE);
      end else begin
         if (open_valid) begin
            lvl     = closing_level();
            trusted = lvl;
            merge_stage(open_start, open_count, lvl);
         end
         open_valid = 1'b1;
         open_level = r.switch_level;
         open_start = r.sample_time;
         open_count = COUNT_ONE;
      end
      // flush closes the open run without setting the trusted level from it, then clears the run state
      if (r.end_of_data) begin
         if (open_valid) begin
            merge_stage(open_start, open_count, closing_level());
         end
         release_merge();
         clear_runs();
      end
      if (burst_runs.size() > 0) begin
         burst_runs[burst_runs.size() - 1].last_of_burst = 1'b1;
      end
   endtask

   // offer one sample request, then record what it should cause
   task automatic send_sample(req_type r, logic typed, logic [1:0] ntyped,
                              rsp_type [MAX_BURST-1:0] typed_runs);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
      predict_runs(r);
      if (typed) begin
         for (int k = 0; k < ntyped; k++) begin
            pending_runs.insert(pending_runs.size(), typed_runs[k]);
         end
      end else begin
         foreach (burst_runs[k]) pending_runs.insert(pending_runs.size(), burst_runs[k]);
      end
   endtask

   // wait until every predicted run has left, plus the pipeline depth
   task automatic wait_idle();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (pending_runs.size() > 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_BITS-1:0] idx, count_type val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_KEEP_LEN) begin
         keep_cfg = val[KEEP_BITS-1:0];
      end else if (idx == CSR_LIFT_LIMIT) begin
         lift_cfg = val;
      end
      csr_writes++;
   endtask

   task automatic set_phase(count_type keep, count_type lift, int idle, int stall);
      write_csr(CSR_KEEP_LEN, keep);
      write_csr(CSR_LIFT_LIMIT, lift);
      idle_pct  = idle;
      stall_pct = stall;
   endtask

   task automatic add_sample(time_type t, logic lvl, logic eod, logic typed,
                             logic [1:0] n, rsp_type r0, rsp_type r1);
      step_row_type row;
      row               = '0;
      row.req           = make_sample(t, lvl, eod);
      row.typed         = typed;
      row.ntyped        = n;
      row.typed_runs[0] = r0;
      row.typed_runs[1] = r1;
      steps.insert(steps.size(), row);
   endtask

   task automatic add_csr(logic [CSR_ADDR_BITS-1:0] idx, count_type val);
      step_row_type row;
      row         = '0;
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      steps.insert(steps.size(), row);
   endtask

   // mostly runs of random length with level toggles, some noise and flushes
   task automatic random_samples(int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            walk_lvl = ~walk_lvl;
            run_left = $urandom_range(1, 6);
         end
         run_left--;
         stamp = ($urandom_range(15) == 0) ? time_type'($urandom)
                                           : stamp + time_type'($urandom_range(1, 4));
         r.sample_time  = stamp;
         r.switch_level = ($urandom_range(99) < 12) ? logic'($urandom_range(1)) : walk_lvl;
         r.end_of_data  = ($urandom_range(24) == 0);
         send_sample(r, 1'b0, 2'd0, '0);
      end
   endtask

   task automatic note_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch (%s): expected start %h len %0d level %b last %b", what,
                  want.run_start_time, want.run_length, want.run_level, want.last_of_burst);
         $display("                 got      start %h len %0d level %b last %b",
                  got.run_start_time, got.run_length, got.run_level, got.last_of_burst);
      end
   endtask

   // result checker: each accepted run against the oldest prediction
   always @(posedge clock) begin : check_runs
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         runs_seen++;
         if (pending_runs.size() == 0) begin
            note_mismatch("unexpected run", '0, rsp_data);
         end else begin
            want = pending_runs.pop_front();
            if (rsp_data.run_start_time != want.run_start_time ||
                rsp_data.run_length != want.run_length ||
                rsp_data.run_level != want.run_level ||
                rsp_data.last_of_burst != want.last_of_burst) begin
               note_mismatch("field", want, rsp_data);
            end
         end
      end
   end

   // receiver: random stall, or a long hold on request
   initial begin : receiver
      int held;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_request = 1'b0;
            pressure_holds++;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d runs still expected", cycle_count,
               pending_runs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      req_type r;
      clear_runs();

      // directed rows, typed results only where obvious
      add_sample(32'd0, 1'b0, 1'b0, 1'b1, 2'd0, '0, '0);
      add_sample(32'd1, 1'b1, 1'b0, 1'b1, 2'd1,
                 make_run(32'd0, 20'd1, 1'b0, 1'b1), '0);
      add_sample(32'd2, 1'b1, 1'b0, 1'b1, 2'd0, '0, '0);
      add_sample(32'd3, 1'b0, 1'b0, 1'b1, 2'd0, '0, '0);
      add_sample(32'd4, 1'b0, 1'b1, 1'b1, 2'd2,
                 make_run(32'd1, 20'd2, 1'b1, 1'b0), make_run(32'd3, 20'd2, 1'b0, 1'b1));
      add_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 2'd1,
                 make_run(32'hFFFF_FFFF, 20'd1, 1'b1, 1'b1), '0);
      add_sample(32'd100, 1'b1, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd101, 1'b0, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd102, 1'b1, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd103, 1'b1, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd104, 1'b0, 1'b1, 1'b0, 2'd0, '0, '0);
      // glitch rule and a short lift limit
      add_csr(CSR_KEEP_LEN, 20'd2);
      add_csr(CSR_LIFT_LIMIT, 20'd3);
      add_sample(32'd200, 1'b1, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd201, 1'b0, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd202, 1'b1, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd203, 1'b1, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd204, 1'b1, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd205, 1'b0, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd206, 1'b0, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd207, 1'b0, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd208, 1'b1, 1'b1, 1'b0, 2'd0, '0, '0);
      // zero lift limit turns every merged high run low
      add_csr(CSR_KEEP_LEN, 20'd0);
      add_csr(CSR_LIFT_LIMIT, 20'd0);
      add_sample(32'd300, 1'b1, 1'b1, 1'b1, 2'd1,
                 make_run(32'd300, 20'd1, 1'b0, 1'b1), '0);
      // widest settings, upper data bits of keep_len dropped
      add_csr(CSR_KEEP_LEN, COUNT_MAX);
      add_csr(CSR_LIFT_LIMIT, COUNT_MAX);
      add_sample(32'd400, 1'b1, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd401, 1'b0, 1'b0, 1'b0, 2'd0, '0, '0);
      add_sample(32'd402, 1'b1, 1'b1, 1'b0, 2'd0, '0, '0);
      // an unused register index changes nothing
      add_csr(CSR_SPARE_INDEX, COUNT_MAX);
      add_sample(32'd403, 1'b0, 1'b1, 1'b0, 2'd0, '0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].is_csr) begin
            write_csr(steps[i].csr_idx, steps[i].csr_val);
         end else begin
            send_sample(steps[i].req, steps[i].typed, steps[i].ntyped, steps[i].typed_runs);
         end
      end

      // random phases over the pacing modes
      set_phase(20'd0, 20'd1, 0, 0);
      random_samples(RANDOM_PER_PHASE);
      set_phase(20'd2, 20'd6, 77, 0);
      random_samples(RANDOM_PER_PHASE);
      set_phase(count_type'($urandom_range(4)), count_type'($urandom_range(1, 12)), 0, 77);
      random_samples(RANDOM_PER_PHASE);
      set_phase(20'd1, 20'd0, 35, 35);
      random_samples(RANDOM_PER_PHASE);

      // long receiver hold while the sender keeps offering, so the queue fills
      set_phase(20'd0, 20'd2, 0, 0);
      hold_request = 1'b1;
      for (int n = 0; n < PRESSURE_SAMPLES; n++) begin
         r = make_sample(time_type'($urandom), logic'(n & 1), 1'b0);
         send_sample(r, 1'b0, 2'd0, '0);
      end
      r = make_sample(time_type'($urandom), 1'b0, 1'b1);
      send_sample(r, 1'b0, 2'd0, '0);

      wait_idle();
      if (pending_runs.size() != 0) begin
         $display("%0d expected runs never arrived", pending_runs.size());
         mismatches += pending_runs.size();
      end
      $display("sent %0d samples (directed, random pacing phases, back-pressure),",
               samples_sent);
      $display("checked %0d runs over %0d register writes and %0d long holds",
               runs_seen, csr_writes, pressure_holds);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
